// ===== sv/assert_macros.svh =====
// assertion helpers for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define KFRS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define KFRS_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/kfrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kfrs_pkg
// Shared widths, types and constants of the k-mer frequency record sorter.
// ----------------------------------------------------------------------------
package kfrs_pkg;

	localparam int MAX_RECORDS = 64;
	localparam int KMER_LEN    = 5;

	localparam int TEXT_W = 40;
	localparam int FREQ_W = 24;
	localparam int REC_W  = TEXT_W + FREQ_W;
	localparam int CNT_W  = $clog2(MAX_RECORDS + 1);

	// only the used character bytes take part in the key
	localparam int TEXT_USED = (KMER_LEN * 8 >= TEXT_W) ? TEXT_W : KMER_LEN * 8;
	localparam logic [TEXT_W-1:0] TEXT_MASK = {TEXT_W{1'b1}} >> (TEXT_W - TEXT_USED);

	localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_RECORDS);

	// record key: frequency above text, so one unsigned compare gives the order
	typedef logic [REC_W-1:0] rec_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctrl_t;

endpackage : kfrs_pkg
`default_nettype wire

// ===== sv/kfrs_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kfrs_cell
// One slot of the sorting row: holds a record, opens a gap for a smaller
// incoming request and shifts towards the head while the run drains.
// ----------------------------------------------------------------------------
module kfrs_cell (
	input  wire                  clk,
	input  kfrs_pkg::cell_ctrl_t ctrl,
	input  kfrs_pkg::rec_t       new_rec,
	input  wire                  occupied,
	input  wire                  left_gt,
	input  kfrs_pkg::rec_t       left_rec,
	input  kfrs_pkg::rec_t       right_rec,
	output logic                 gt,
	output kfrs_pkg::rec_t       rec
);
	import kfrs_pkg::*;

	rec_t rec_q;

	// empty slots count as larger than anything
	assign gt  = !occupied || (new_rec < rec_q);
	assign rec = rec_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert && gt) begin
			rec_q <= left_gt ? left_rec : new_rec;
		end else if (ctrl.shift) begin
			rec_q <= right_rec;
		end
	end

endmodule : kfrs_cell
`default_nettype wire

// ===== sv/kmer_frequency_record_sorter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kmer_frequency_record_sorter
// Collects a batch of k-mer records in a row of insertion cells kept in
// ascending (frequency, text) order and streams them out from the head.
//
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   kmer_text, frequency, last
// out      output     out_valid / out_ready kmer_text_res, frequency_res,
//                                            last_res, overflowed
//
// loading takes one record per cycle while in_ready is high; every cell compares
// the new record in the same cycle and the row opens a gap at the insertion point
// the stored records drain from the head in order while out_ready stays high
// in_ready is low while the run drains and rises the cycle after the final
// result is taken
// after reset the row is empty and loading can start at once
// ----------------------------------------------------------------------------
module kmer_frequency_record_sorter (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [kfrs_pkg::TEXT_W-1:0]  kmer_text,
	input  wire  [kfrs_pkg::FREQ_W-1:0]  frequency,
	input  wire                          last,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [kfrs_pkg::TEXT_W-1:0]  kmer_text_res,
	output logic [kfrs_pkg::FREQ_W-1:0]  frequency_res,
	output logic                         last_res,
	output logic                         overflowed
);
	import kfrs_pkg::*;

	localparam logic ST_LOAD  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] count_q;
	logic             overflow_q;

	logic       in_fire;
	logic       out_fire;
	logic       room;
	cell_ctrl_t ctrl;
	rec_t       new_rec;

	rec_t                   cell_rec [MAX_RECORDS];
	logic [MAX_RECORDS-1:0] cell_gt;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_DRAIN);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;
	assign room      = (count_q < CAPACITY);

	assign ctrl.insert = in_fire && room;
	assign ctrl.shift  = out_fire;

	assign new_rec = {frequency, kmer_text & TEXT_MASK};

	genvar gi;
	generate
		for (gi = 0; gi < MAX_RECORDS; gi++) begin : g_cell
			localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
			logic occ;
			logic lgt;
			rec_t lrec;
			rec_t rrec;

			assign occ = (IDX < count_q);
			if (gi == 0) begin : g_head
				assign lgt  = 1'b0;
				assign lrec = new_rec;
			end else begin : g_body
				assign lgt  = cell_gt[gi-1];
				assign lrec = cell_rec[gi-1];
			end
			if (gi == MAX_RECORDS - 1) begin : g_tail
				assign rrec = cell_rec[gi];
			end else begin : g_mid
				assign rrec = cell_rec[gi+1];
			end

			kfrs_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.new_rec   (new_rec),
				.occupied  (occ),
				.left_gt   (lgt),
				.left_rec  (lrec),
				.right_rec (rrec),
				.gt        (cell_gt[gi]),
				.rec       (cell_rec[gi])
			);
		end
	endgenerate

	assign kmer_text_res = cell_rec[0][TEXT_W-1:0];
	assign frequency_res = cell_rec[0][REC_W-1:TEXT_W];
	assign last_res      = (count_q == CNT_W'(1));
	assign overflowed    = overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							overflow_q <= 1'b1;
						end
						if (last) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (out_fire) begin
						count_q <= count_q - CNT_W'(1);
						if (last_res) begin
							state_q    <= ST_LOAD;
							overflow_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

`include "assert_macros.svh"

	`KFRS_ASSERT(a_one_side, !(in_ready && out_valid), "load and drain overlap")
	`KFRS_ASSERT(a_cap, count_q <= CAPACITY, "record count beyond capacity")
	`KFRS_ASSERT(a_sorted, (out_valid && count_q >= CNT_W'(2)) |-> (cell_rec[0] <= cell_rec[1]), "head of row out of order")
	`KFRS_ASSERT(a_run_end, (out_fire && last_res) |=> (in_ready && count_q == '0 && !overflowed), "batch state not cleared after run")
	`KFRS_ASSERT(a_run_cont, (out_fire && !last_res) |=> out_valid, "run stopped early")

endmodule : kmer_frequency_record_sorter
`default_nettype wire
